[hw/rtl/smm_pkg.sv]
package smm_pkg;

    localparam int CFG_W       = 4;
    localparam int PROD_W      = 35;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    // item opcodes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_size;
        logic [CFG_W-1:0] cols_b;
    } t_dims;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // travels with each MAC step down the pipeline
    typedef struct packed {
        logic             first;
        logic             lastk;
        logic             lastent;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

[hw/rtl/small_matrix_multiply.sv]
// Integer matrix multiplier for matrices of up to MAX_DIM by MAX_DIM signed
// elements. Load items (op 0 for A, op 1 for B) write one element at
// row*MAX_DIM+col; loads outside the store and op 3 are dropped. A run item
// (op 2) emits rows_a*cols_b product entries in row-major order, each the
// wrapped 35-bit sum over inner_size products, with o_last on the final
// entry. A run occupies the single multiply-accumulate unit, which it holds
// while the output is stalled; the next command starts after the read,
// multiply and accumulate stages have drained. A four-entry command queue
// sits between the input channel and the execution unit, so loads keep being
// taken while a run is in progress, until the queue is full. Size registers
// of 0 act as 1 and values above MAX_DIM act as MAX_DIM; they are sampled
// when a run starts. Every element a run reads must have been loaded before.
module small_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [IDX_W-1:0]             i_row,
    input  logic [IDX_W-1:0]             i_col,
    input  logic signed [ELEM_WIDTH-1:0] i_element,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [IDX_W-1:0]             o_out_row,
    output logic [IDX_W-1:0]             o_out_col,
    output logic signed [PROD_W-1:0]     o_product,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMD_W = 2 + AW + ELEM_WIDTH;

    logic             cfg_wr;
    logic [CFG_W-1:0] r_rows_a, r_inner_size, r_cols_b;
    t_dims            dims;

    logic             push, pop;
    logic [CMD_W-1:0] cmd_in, cmd_out;
    t_fifo_stat       stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= DIM_RESET;
            r_inner_size <= DIM_RESET;
            r_cols_b     <= DIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ROWS_A: r_rows_a     <= pwdata[CFG_W-1:0];
                REG_INNER:  r_inner_size <= pwdata[CFG_W-1:0];
                REG_COLS_B: r_cols_b     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS_A: prdata = 32'(r_rows_a);
            REG_INNER:  prdata = 32'(r_inner_size);
            REG_COLS_B: prdata = 32'(r_cols_b);
            default:    prdata = '0;
        endcase
    end

    assign dims.rows_a     = r_rows_a;
    assign dims.inner_size = r_inner_size;
    assign dims.cols_b     = r_cols_b;

    smm_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_element  (i_element),
        .i_stat     (stat),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    smm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (cmd_in),
        .i_pop   (pop),
        .o_dout  (cmd_out),
        .o_stat  (stat)
    );

    smm_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (dims),
        .i_stat      (stat),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_product   (o_product),
        .o_last      (o_last)
    );

endmodule

[hw/rtl/smm_ram.sv]
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/smm_fifo.sv]
module smm_fifo
    import smm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output t_fifo_stat       o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    assign n_count = r_count + CW'(i_push) - CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    assign o_dout       = r_mem[r_rp];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

[hw/rtl/smm_front.sv]
module smm_front
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = $clog2(DEPTH),
    localparam int CMD_W = 2 + AW + ELEM_WIDTH
) (
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [IDX_W-1:0]             i_row,
    input  logic [IDX_W-1:0]             i_col,
    input  logic signed [ELEM_WIDTH-1:0] i_element,
    input  t_fifo_stat                   i_stat,
    output logic                         o_push,
    output logic [CMD_W-1:0]             o_cmd
);

    logic          in_range;
    logic          keep;
    logic [AW-1:0] addr;

    assign in_range = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
    assign addr     = AW'(i_row * MAX_DIM + i_col);

    // unused opcode and loads outside the store are dropped here
    always_comb begin
        keep = 1'b0;
        if (i_op == OP_RUN) begin
            keep = 1'b1;
        end else if (i_op inside {OP_LOAD_A, OP_LOAD_B}) begin
            keep = in_range;
        end
    end

    assign o_in_stall = i_stat.full;
    assign o_push     = i_in_valid && !i_stat.full && keep;
    assign o_cmd      = {i_op, addr, i_element};

endmodule

[hw/rtl/smm_back.sv]
module smm_back
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = $clog2(DEPTH),
    localparam int CMD_W = 2 + AW + ELEM_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dims                    i_dims,
    input  t_fifo_stat               i_stat,
    input  logic [CMD_W-1:0]         i_cmd,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [PROD_W-1:0] o_product,
    output logic                     o_last
);

    localparam int DW    = $clog2(MAX_DIM);
    localparam int MUL_W = 2 * ELEM_WIDTH;

    function automatic logic [DW-1:0] last_idx(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_DIM) begin
            return DW'(MAX_DIM - 1);
        end else begin
            return DW'(v - 1'b1);
        end
    endfunction

    logic [1:0]            cmd_op;
    logic [AW-1:0]         cmd_addr;
    logic [ELEM_WIDTH-1:0] cmd_data;

    logic          busy, start, adv, issue;
    logic          we_a, we_b;
    logic          s_end, c_end, r_end;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    t_tag          tag;

    logic          r_run;
    logic [DW-1:0] r_m, r_k, r_n;
    logic [DW-1:0] r_r, r_c, r_s;

    logic [ELEM_WIDTH-1:0] a_rd, b_rd;
    logic                  r_v1, r_v2;
    t_tag                  r_t1, r_t2;
    logic signed [MUL_W-1:0]  r_prod;
    logic signed [PROD_W-1:0] prod_ext, n_acc, r_acc;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic signed [PROD_W-1:0] r_out_product;
    logic                     r_out_last;

    assign cmd_op   = i_cmd[CMD_W-1 -: 2];
    assign cmd_addr = i_cmd[ELEM_WIDTH +: AW];
    assign cmd_data = i_cmd[ELEM_WIDTH-1:0];

    // a new command waits until the previous run has left the MAC pipe
    assign busy  = r_run || r_v1 || r_v2;
    assign o_pop = !busy && !i_stat.empty;
    assign start = o_pop && (cmd_op == OP_RUN);
    assign we_a  = o_pop && (cmd_op == OP_LOAD_A);
    assign we_b  = o_pop && (cmd_op == OP_LOAD_B);

    // whole pipe holds while the output register is full and stalled
    assign adv   = !r_out_valid || !i_out_stall;
    assign issue = r_run && adv;

    assign s_end = (r_s == r_k);
    assign c_end = (r_c == r_n);
    assign r_end = (r_r == r_m);

    assign rd_addr_a = AW'(r_r * MAX_DIM + r_s);
    assign rd_addr_b = AW'(r_s * MAX_DIM + r_c);

    assign tag.first   = (r_s == '0);
    assign tag.lastk   = s_end;
    assign tag.lastent = s_end && c_end && r_end;
    assign tag.row     = IDX_W'(r_r);
    assign tag.col     = IDX_W'(r_c);

    smm_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (cmd_addr),
        .i_wdata (cmd_data),
        .i_re    (issue),
        .i_raddr (rd_addr_a),
        .o_rdata (a_rd)
    );

    smm_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (cmd_addr),
        .i_wdata (cmd_data),
        .i_re    (issue),
        .i_raddr (rd_addr_b),
        .o_rdata (b_rd)
    );

    // row / column / inner-index sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (start) begin
            r_run <= 1'b1;
            r_m   <= last_idx(i_dims.rows_a);
            r_k   <= last_idx(i_dims.inner_size);
            r_n   <= last_idx(i_dims.cols_b);
            r_r   <= '0;
            r_c   <= '0;
            r_s   <= '0;
        end else if (issue) begin
            if (s_end) begin
                r_s <= '0;
                if (c_end) begin
                    r_c <= '0;
                    if (r_end) begin
                        r_run <= 1'b0;
                    end else begin
                        r_r <= r_r + 1'b1;
                    end
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end else begin
                r_s <= r_s + 1'b1;
            end
        end
    end

    // products are sign-extended to the result width; the sum wraps there
    assign prod_ext = PROD_W'(r_prod);
    assign n_acc    = r_t2.first ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= issue;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 && r_t2.lastk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t1   <= tag;
            r_t2   <= r_t1;
            r_prod <= $signed(a_rd) * $signed(b_rd);
            if (r_v2) begin
                r_acc <= n_acc;
                if (r_t2.lastk) begin
                    r_out_row     <= r_t2.row;
                    r_out_col     <= r_t2.col;
                    r_out_product <= n_acc;
                    r_out_last    <= r_t2.lastent;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_product   = r_out_product;
    assign o_last      = r_out_last;

endmodule

[hw/rtl/smm_checker.sv]
module smm_checker
    import smm_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [IDX_W-1:0]         o_out_row,
    input logic [IDX_W-1:0]         o_out_col,
    input logic signed [PROD_W-1:0] o_product,
    input logic                     o_last
);

    // reset empties the queue and the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_product)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last))
        else $error("stalled result changed");

    // back-to-back entries of one run go in row-major order
    a_row_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) ##1 (o_out_valid && !i_out_stall)
        |-> (o_out_row == $past(o_out_row) && o_out_col == $past(o_out_col) + 3'd1)
            || (o_out_col == '0 && o_out_row == $past(o_out_row) + 3'd1))
        else $error("product entries out of order");

    // a run starts at entry (0,0)
    a_first_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) ##1 (o_out_valid && !i_out_stall)
        |-> o_out_row == '0 && o_out_col == '0)
        else $error("run does not start at the first entry");

endmodule

bind small_matrix_multiply smm_checker u_smm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_product   (o_product),
    .o_last      (o_last)
);

[sim/tb_small_matrix_multiply.sv]
`timescale 1ns / 1ps

module tb_small_matrix_multiply;
    import smm_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int ELEM_W  = 16;
    localparam int SLOTS   = MAX_DIM * MAX_DIM;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [PROD_W-1:0] value;
        logic                     last;
    } t_entry;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_op        = OP_LOAD_A;
    logic [IDX_W-1:0]         i_row       = '0;
    logic [IDX_W-1:0]         i_col       = '0;
    logic signed [ELEM_W-1:0] i_element   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [IDX_W-1:0]         o_out_row;
    logic [IDX_W-1:0]         o_out_col;
    logic signed [PROD_W-1:0] o_product;
    logic                     o_last;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [3:0]               paddr       = '0;
    logic [31:0]              pwdata      = '0;
    logic [31:0]              prdata;
    logic                     pready;

    small_matrix_multiply #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_element   (i_element),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_product   (o_product),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic signed [ELEM_W-1:0] mat_a [SLOTS];
    logic signed [ELEM_W-1:0] mat_b [SLOTS];
    bit                       loaded_a [SLOTS];
    bit                       loaded_b [SLOTS];
    logic [CFG_W-1:0]         dim_m = DIM_RESET;
    logic [CFG_W-1:0]         dim_k = DIM_RESET;
    logic [CFG_W-1:0]         dim_n = DIM_RESET;
    t_entry                   products_due [$];

    int fail_count  = 0;
    int items_sent  = 0;
    bit calm        = 1'b0;
    int hold_cycles = 0;
    int hold_left   = 0;

    function automatic int eff_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return CFG_W'($urandom_range(15, MAX_DIM + 1));
            2: return CFG_W'(MAX_DIM);
            default: return CFG_W'($urandom_range(4, 1));
        endcase
    endfunction

    // update the stores, or compute the whole product for a run
    task automatic apply_command(logic [1:0] op, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] col, logic signed [ELEM_W-1:0] elem);
        int m, k, n;
        logic signed [63:0] acc;
        t_entry e;
        case (op)
            OP_LOAD_A: begin
                mat_a[row * MAX_DIM + col]    = elem;
                loaded_a[row * MAX_DIM + col] = 1'b1;
            end
            OP_LOAD_B: begin
                mat_b[row * MAX_DIM + col]    = elem;
                loaded_b[row * MAX_DIM + col] = 1'b1;
            end
            OP_RUN: begin
                m = eff_dim(dim_m);
                k = eff_dim(dim_k);
                n = eff_dim(dim_n);
                for (int r = 0; r < m; r++) begin
                    for (int c = 0; c < n; c++) begin
                        acc = '0;
                        for (int s = 0; s < k; s++) begin
                            acc += mat_a[r * MAX_DIM + s] * mat_b[s * MAX_DIM + c];
                        end
                        e.row   = IDX_W'(r);
                        e.col   = IDX_W'(c);
                        e.value = acc[PROD_W-1:0];
                        e.last  = (r == m - 1) && (c == n - 1);
                        products_due.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // valid stays high after a transfer; only idling or a drain lowers it
    task automatic send_item(logic [1:0] op, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [ELEM_W-1:0] elem);
        while (!calm && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_row      <= row;
        i_col      <= col;
        i_element  <= elem;
        do @(posedge i_clk); while (o_in_stall);
        apply_command(op, row, col, elem);
        if (op inside {OP_LOAD_A, OP_LOAD_B, OP_RUN}) items_sent++;
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dims(logic [CFG_W-1:0] m, logic [CFG_W-1:0] k, logic [CFG_W-1:0] n);
        apb_write(REG_ROWS_A, 32'(m));
        apb_write(REG_INNER, 32'(k));
        apb_write(REG_COLS_B, 32'(n));
        dim_m = m;
        dim_k = k;
        dim_n = n;
    endtask

    // queued loads may still be executing after the last product leaves
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (products_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // a run may only read elements that were written
    task automatic load_missing_elements();
        int m, k, n;
        m = eff_dim(dim_m);
        k = eff_dim(dim_k);
        n = eff_dim(dim_n);
        for (int r = 0; r < m; r++)
            for (int s = 0; s < k; s++)
                if (!loaded_a[r * MAX_DIM + s])
                    send_item(OP_LOAD_A, IDX_W'(r), IDX_W'(s), rand_elem());
        for (int s = 0; s < k; s++)
            for (int c = 0; c < n; c++)
                if (!loaded_b[s * MAX_DIM + c])
                    send_item(OP_LOAD_B, IDX_W'(s), IDX_W'(c), rand_elem());
    endtask

    task automatic load_random();
        send_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A,
                  IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)), rand_elem());
    endtask

    // reset sizes are 8x8x8: fill both stores in shuffled order, no idling
    task automatic test_reset_size_run();
        int order [2 * SLOTS];
        int j, t;
        calm = 1'b1;
        for (int i = 0; i < 2 * SLOTS; i++) order[i] = i;
        for (int i = 2 * SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i]) begin
            t = order[i] % SLOTS;
            send_item(order[i] < SLOTS ? OP_LOAD_A : OP_LOAD_B,
                      IDX_W'(t / MAX_DIM), IDX_W'(t % MAX_DIM), rand_elem());
        end
        send_item(OP_RUN, '0, '0, '0);
        wait_idle();
        calm = 1'b0;
    endtask

    task automatic test_extreme_values();
        wait_idle();
        set_dims(4'd1, 4'd8, 4'd1);
        for (int s = 0; s < MAX_DIM; s++) begin
            send_item(OP_LOAD_A, '0, IDX_W'(s), 16'sh8000);
            send_item(OP_LOAD_B, IDX_W'(s), '0, 16'sh8000);
        end
        send_item(OP_RUN, 3'd7, 3'd7, 16'sh7fff);
        send_item(OP_UNUSED, 3'd7, 3'd7, 16'sh7fff);
        wait_idle();
        set_dims(4'd1, 4'd1, 4'd1);
        send_item(OP_LOAD_A, '0, '0, 16'sh7fff);
        send_item(OP_LOAD_B, '0, '0, 16'sh8000);
        send_item(OP_RUN, '0, '0, '0);
        wait_idle();
    endtask

    // zero acts as one, anything above the maximum as the maximum
    task automatic test_size_clamp();
        set_dims(4'd0, 4'd15, 4'd0);
        load_missing_elements();
        send_item(OP_RUN, '0, '0, '0);
        wait_idle();
        set_dims(4'd15, 4'd1, 4'd9);
        load_missing_elements();
        send_item(OP_RUN, '0, '0, '0);
        wait_idle();
    endtask

    // receiver holds off while loads pile up behind a run
    task automatic test_backpressure();
        set_dims(4'd2, 4'd3, 4'd2);
        load_missing_elements();
        hold_cycles = 300;
        send_item(OP_RUN, '0, '0, '0);
        repeat (10) load_random();
        load_missing_elements();
        send_item(OP_RUN, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_runs();
        int goal;
        goal = items_sent + 16;
        while (items_sent < goal) begin
            if ($urandom_range(1)) begin
                wait_idle();
                set_dims(pick_dim(), pick_dim(), pick_dim());
            end
            repeat ($urandom_range(6)) begin
                if ($urandom_range(9) == 0)
                    send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                              ELEM_W'($urandom));
                else
                    load_random();
            end
            load_missing_elements();
            send_item(OP_RUN, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_left   = hold_cycles;
            hold_cycles = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 33);
        end
    end

    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (products_due.size() == 0) begin
                $error("unexpected product transfer: row %0d col %0d product %0d",
                       o_out_row, o_out_col, o_product);
                fail_count++;
            end else begin
                want = products_due.pop_front();
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, actual %0d", want.row, o_out_row);
                    fail_count++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, actual %0d", want.col, o_out_col);
                    fail_count++;
                end
                if (o_product !== want.value) begin
                    $error("product: expected %0d, actual %0d", want.value, o_product);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_size_run();
        test_extreme_values();
        test_size_clamp();
        test_backpressure();
        test_random_runs();
        set_dims(4'd8, 4'd8, 4'd8);
        load_missing_elements();
        send_item(OP_RUN, '0, '0, '0);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/smm_pkg.sv
hw/rtl/smm_ram.sv
hw/rtl/smm_fifo.sv
hw/rtl/smm_front.sv
hw/rtl/smm_back.sv
hw/rtl/small_matrix_multiply.sv
hw/rtl/smm_checker.sv
sim/tb_small_matrix_multiply.sv
